>>> src/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared constants, register map, types and the key character table of the
// keypad debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int KEY_W       = $clog2(NUM_KEYS);
  localparam int HELD_CNT_W  = $clog2(NUM_KEYS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam int THR_W   = 8;
  localparam int TIME_W  = 16;
  localparam int TICK_W  = 10;
  localparam int RAW_W   = 16;
  localparam int CHAR_W  = 7;
  localparam int INDEX_W = 4;
  localparam int ADDR_W  = 4;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_PRESS_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD     = 2'd2;

  localparam logic [THR_W-1:0]  RST_PRESS_THRESHOLD = 8'd10;
  localparam logic [TIME_W-1:0] RST_REPEAT_INTERVAL = 16'd1000;
  localparam logic [TICK_W-1:0] RST_TICK_PERIOD     = 10'd10;

  localparam logic [CHAR_W-1:0] KEY_GLYPHS [16] = '{
    7'h31, 7'h32, 7'h33, 7'h41,   // 1 2 3 A
    7'h34, 7'h35, 7'h36, 7'h42,   // 4 5 6 B
    7'h37, 7'h38, 7'h39, 7'h43,   // 7 8 9 C
    7'h2A, 7'h30, 7'h3D, 7'h2F    // * 0 = /
  };

  // State of one key as it goes into and comes out of the update unit.
  typedef struct packed {
    logic [THR_W-1:0]  count;
    logic              pressed;
    logic [TIME_W-1:0] held;
  } key_state_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [TIME_W-1:0] interval;
    logic [TICK_W-1:0] tick;
  } key_cfg_t;

  // Keys past the sixteenth have no legend and report a zero character.
  function automatic logic [CHAR_W-1:0] key_char_of(input logic [KEY_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (int'(idx) < 16) begin
      c = KEY_GLYPHS[int'(idx) % 16];
    end
    return c;
  endfunction

endpackage

>>> src/kpd_key_unit.sv
// ----------------------------------------------------------------------------
// kpd_key_unit
// Shared per-key update: integrator step, press/release decision and the
// saturating held-time add. One key is passed through it per clock.
// ----------------------------------------------------------------------------
module kpd_key_unit (
  input  logic                closed,
  input  kpd_pkg::key_state_t cur,
  input  kpd_pkg::key_cfg_t   cfg,
  output kpd_pkg::key_state_t upd
);
  import kpd_pkg::*;

  logic [THR_W-1:0]  count_next;
  logic [TIME_W:0]   held_sum;

  always_comb begin
    count_next = cur.count;
    if (closed) begin
      if (cur.count < cfg.threshold) begin
        count_next = cur.count + THR_W'(1);
      end
    end else if (cur.count != '0) begin
      count_next = cur.count - THR_W'(1);
    end
  end

  assign held_sum = {1'b0, cur.held} + (TIME_W + 1)'(cfg.tick);

  always_comb begin
    upd.count = count_next;
    if (cur.pressed) begin
      upd.held    = held_sum[TIME_W] ? '1 : held_sum[TIME_W-1:0];
      upd.pressed = (count_next != '0);
    end else begin
      upd.held    = cfg.interval;
      upd.pressed = (count_next >= cfg.threshold);
    end
  end

endmodule

>>> src/keypad_debounce_autorepeat_core.sv
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat_core
// Integrating debouncer with auto-repeat for a 16-key matrix keypad.
//
// Each request on req_* carries one raw matrix sample (one scan tick). The
// block walks the keys one per clock through a shared update unit; when one
// or two keys were pressed as the tick began, it walks them again to pick
// out keys due for emission, one result per key on rsp_*, in ascending key
// order. The final result of a tick has last_of_tick set; a tick that emits
// nothing gives a single result with key_valid low. A request is taken only
// when the block is idle. A tick runs through an accept step, the update
// walk over all keys, the scan walk (if taken) and a finish step; the two
// walks over the key store set the length of a tick.
// Results sit in an output register; while the receiver stalls, the scan
// holds on the next emitting key and resumes once the register frees up.
// Reset clears all key state and loads the register defaults (threshold 10,
// repeat interval 1000 ms, tick period 10 ms). Registers are to be written
// over the APB port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module keypad_debounce_autorepeat_core (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kpd_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Scan tick requests
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [kpd_pkg::RAW_W-1:0]       raw_keys,
  // Results
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            key_valid,
  output logic [kpd_pkg::INDEX_W-1:0]     key_index,
  output logic [kpd_pkg::CHAR_W-1:0]      key_char,
  output logic                            sound_on,
  output logic                            last_of_tick
);
  import kpd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

  // Configuration registers
  logic [THR_W-1:0]  press_threshold;
  logic [TIME_W-1:0] repeat_interval_ms;
  logic [TICK_W-1:0] tick_period_ms;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold    <= RST_PRESS_THRESHOLD;
      repeat_interval_ms <= RST_REPEAT_INTERVAL;
      tick_period_ms     <= RST_TICK_PERIOD;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PRESS_THRESHOLD: press_threshold    <= pwdata[THR_W-1:0];
        REG_REPEAT_INTERVAL: repeat_interval_ms <= pwdata[TIME_W-1:0];
        REG_TICK_PERIOD:     tick_period_ms     <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PRESS_THRESHOLD: prdata = 32'(press_threshold);
      REG_REPEAT_INTERVAL: prdata = 32'(repeat_interval_ms);
      REG_TICK_PERIOD:     prdata = 32'(tick_period_ms);
      default:             prdata = '0;
    endcase
  end

  // Key store and sequencer
  state_t                state;
  logic [NUM_KEYS-1:0]   raw;
  logic [KEY_W-1:0]      ptr;
  logic [THR_W-1:0]      count_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]   pressed_mem;
  logic [TIME_W-1:0]     held_mem  [NUM_KEYS];
  logic [HELD_CNT_W-1:0] held_count;
  logic                  sound;
  logic [EMIT_CNT_W-1:0] emit_count;
  logic                  pend_valid;
  logic [KEY_W-1:0]      pend_idx;

  key_state_t            cur;
  key_state_t            upd;
  key_cfg_t              ucfg;
  logic [HELD_CNT_W-1:0] held_count_next;
  logic                  out_free;
  logic                  emit_hit;
  logic                  rsp_load;

  assign cur.count   = count_mem[ptr];
  assign cur.pressed = pressed_mem[ptr];
  assign cur.held    = held_mem[ptr];

  assign ucfg.threshold = press_threshold;
  assign ucfg.interval  = repeat_interval_ms;
  assign ucfg.tick      = tick_period_ms;

  kpd_key_unit u_key_unit (
    .closed (raw[ptr]),
    .cur    (cur),
    .cfg    (ucfg),
    .upd    (upd)
  );

  assign req_ready       = (state == ST_IDLE);
  assign out_free        = !rsp_valid || rsp_ready;
  assign held_count_next = held_count + HELD_CNT_W'(cur.pressed);
  assign emit_hit        = cur.pressed && (cur.held >= repeat_interval_ms) &&
                           (emit_count != EMIT_CNT_W'(MAX_RESULTS));
  // A new result enters the output register this cycle.
  assign rsp_load        = ((state == ST_SCAN) && emit_hit && pend_valid && out_free) ||
                           ((state == ST_FINISH) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ptr          <= '0;
      held_count   <= '0;
      sound        <= 1'b0;
      emit_count   <= '0;
      pend_valid   <= 1'b0;
      pressed_mem  <= '0;
      rsp_valid    <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        count_mem[i] <= '0;
        held_mem[i]  <= '0;
      end
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            raw        <= NUM_KEYS'(raw_keys);
            ptr        <= '0;
            held_count <= '0;
            state      <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          count_mem[ptr]   <= upd.count;
          pressed_mem[ptr] <= upd.pressed;
          held_mem[ptr]    <= upd.held;
          held_count       <= held_count_next;
          if (ptr == LAST_KEY) begin
            ptr        <= '0;
            emit_count <= '0;
            pend_valid <= 1'b0;
            // Sound counts keys that were pressed as the tick began.
            sound <= (held_count_next == HELD_CNT_W'(1)) ||
                     (held_count_next == HELD_CNT_W'(2));
            if ((held_count_next == HELD_CNT_W'(1)) ||
                (held_count_next == HELD_CNT_W'(2))) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end else begin
            ptr <= ptr + KEY_W'(1);
          end
        end
        ST_SCAN: begin
          // An emitting key is held back until the next hit or the finish so that
          // the final result of the tick can be marked; a second hit must wait for room.
          if (!(emit_hit && pend_valid && !out_free)) begin
            if (emit_hit) begin
              if (pend_valid) begin
                key_valid    <= 1'b1;
                key_index    <= INDEX_W'(pend_idx);
                key_char     <= key_char_of(pend_idx);
                sound_on     <= 1'b1;
                last_of_tick <= 1'b0;
              end
              pend_valid    <= 1'b1;
              pend_idx      <= ptr;
              held_mem[ptr] <= '0;
              emit_count    <= emit_count + EMIT_CNT_W'(1);
            end
            if (ptr == LAST_KEY) begin
              ptr   <= '0;
              state <= ST_FINISH;
            end else begin
              ptr <= ptr + KEY_W'(1);
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            key_valid    <= pend_valid;
            key_index    <= pend_valid ? INDEX_W'(pend_idx) : '0;
            key_char     <= pend_valid ? key_char_of(pend_idx) : '0;
            sound_on     <= sound;
            last_of_tick <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
